// ----- hdl/htlp_pkg.sv -----
package htlp_pkg;

  localparam logic [63:0] FnvBasis = 64'hCBF29CE484222325;
  localparam logic [63:0] FnvPrime = 64'h00000100000001B3;

  // Number of table slots; a power of two so the home slot is the low hash bits.
  localparam int Capacity = 256;

  typedef enum logic [1:0] {
    FUNC_SET = 2'd0,
    FUNC_GET = 2'd1,
    FUNC_DEL = 2'd2,
    FUNC_NOP = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_HASH,
    FS_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_READ,
    BS_WAIT,
    BS_CHECK,
    BS_REPLY
  } back_state_e;

  // Classified request carried from the hashing front to the probing back.
  typedef struct packed {
    func_e       func;
    logic [3:0]  key_len;
    logic [63:0] key;
    logic [63:0] value;
    logic [63:0] hash;
  } req_t;

endpackage

// ----- hdl/hash_table_linear_probe_engine.sv -----
// Linear-probing key-value table with FNV-1a home slots.
// Input channel: valid_i/ready_o with func_i (0 set, 1 get, 2 delete),
// key_len_i, key_bytes_i and write_value_i. Output channel: valid_o/ready_i
// with status_o (0 ok, 1 miss, 2 full) and read_value_o.
// The front hashes one key byte per cycle and hands the request through a
// two-entry queue to the back, which walks the table slot by slot (read,
// wait, then compare; the memory read is registered), then offers the result.
// The front and the back work on different transactions at the same time,
// so throughput is set by the slower of the two.
// After reset the back clears the occupied and tombstone flags one slot per
// cycle, over all slots, before it takes its first request; the front and the
// queue still accept up to three transactions meanwhile.
// A stalled receiver holds the result; the queue then fills and the front
// drops ready_o until space returns.
module hash_table_linear_probe_engine
  import htlp_pkg::*;
#(
  parameter int KEY_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [1:0]  func_i,
  input  logic [3:0]  key_len_i,
  input  logic [63:0] key_bytes_i,
  input  logic [63:0] write_value_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [1:0]  status_o,
  output logic [63:0] read_value_o
);

  logic f_valid, f_ready, b_valid, b_ready;
  req_t f_req, b_req;

  htlp_front #(.KEY_BYTES(KEY_BYTES)) u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .func_i, .key_len_i, .key_bytes_i,
    .write_value_i, .req_valid_o(f_valid), .req_ready_i(f_ready), .req_o(f_req)
  );

  htlp_queue u_queue (
    .clk_i, .rst_ni, .push_valid_i(f_valid), .push_ready_o(f_ready),
    .push_i(f_req), .pop_valid_o(b_valid), .pop_ready_i(b_ready), .pop_o(b_req)
  );

  htlp_back u_back (
    .clk_i, .rst_ni, .req_valid_i(b_valid), .req_ready_o(b_ready),
    .req_i(b_req), .valid_o, .ready_i, .status_o, .read_value_o
  );

endmodule

// ----- hdl/htlp_front.sv -----
module htlp_front
  import htlp_pkg::*;
#(
  parameter int KEY_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [1:0]  func_i,
  input  logic [3:0]  key_len_i,
  input  logic [63:0] key_bytes_i,
  input  logic [63:0] write_value_i,
  output logic        req_valid_o,
  input  logic        req_ready_i,
  output req_t        req_o
);

  localparam logic [3:0] MaxLen = 4'(KEY_BYTES);

  front_state_e state_q, state_d;
  req_t         req_q, req_d;
  logic [3:0]   byte_q, byte_d;

  logic [3:0]  len_sat;
  logic [63:0] key_mask;
  logic [63:0] mix;

  always_comb begin
    len_sat = (key_len_i > MaxLen) ? MaxLen : key_len_i;
    key_mask = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < len_sat) key_mask[8*b +: 8] = 8'hFF;
    end
  end

  // One FNV-1a byte step per cycle: xor then multiply.
  assign mix = (req_q.hash ^ {56'd0, req_q.key[8*byte_q[2:0] +: 8]}) * FnvPrime;

  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    byte_d  = byte_q;
    ready_o = 1'b0;
    req_valid_o = 1'b0;
    unique case (state_q)
      FS_IDLE: begin
        ready_o = 1'b1;
        if (valid_i) begin
          req_d.func    = func_e'(func_i);
          req_d.key_len = len_sat;
          req_d.key     = key_bytes_i & key_mask;
          req_d.value   = write_value_i;
          req_d.hash    = FnvBasis;
          byte_d        = '0;
          state_d       = FS_HASH;
        end
      end
      FS_HASH: begin
        if (byte_q >= req_q.key_len) begin
          state_d = FS_PUSH;
        end else begin
          req_d.hash = mix;
          byte_d     = byte_q + 4'd1;
        end
      end
      FS_PUSH: begin
        req_valid_o = 1'b1;
        if (req_ready_i) state_d = FS_IDLE;
      end
      default: state_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    byte_q <= byte_d;
  end

  assign req_o = req_q;

endmodule

// ----- hdl/htlp_queue.sv -----
module htlp_queue
  import htlp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  req_t push_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output req_t pop_o
);

  req_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= push_i;
  end

endmodule

// ----- hdl/htlp_back.sv -----
module htlp_back
  import htlp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  req_t        req_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [1:0]  status_o,
  output logic [63:0] read_value_o
);

  localparam int AW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int CW = $clog2(Capacity + 1);
  localparam logic [CW-1:0] CapCount = CW'(Capacity);

  // Payload and flag memories; flags are {occupied, tombstone}, cleared by a
  // pass over all slots after reset.
  logic [63:0] key_mem   [Capacity];
  logic [3:0]  len_mem   [Capacity];
  logic [63:0] val_mem   [Capacity];
  logic [1:0]  flag_mem  [Capacity];

  back_state_e state_q, state_d;
  req_t        req_q;
  logic [AW-1:0] pos_q, pos_d, tpos_q, tpos_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          have_tomb_q, have_tomb_d;
  logic [CW-1:0] steps_q, steps_d;
  logic [1:0]    status_q, status_d;
  logic [63:0]   rd_q, rd_d;
  logic [63:0]   rkey_q, rval_q;
  logic [3:0]    rlen_q;
  logic          rocc_q, rtomb_q;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          wr_full;      // store key, length and value
  logic          set_occ, set_tomb;
  logic          flag_we;
  logic [AW-1:0] flag_addr;
  logic [1:0]    flag_wdata;
  logic [63:0]   home_big;

  assign home_big = req_i.hash % 64'(Capacity);

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    tpos_d      = tpos_q;
    clr_d       = clr_q;
    have_tomb_d = have_tomb_q;
    steps_d     = steps_q;
    status_d    = status_q;
    rd_d        = rd_q;
    req_ready_o = 1'b0;
    valid_o     = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = pos_q;
    wr_full     = 1'b0;
    set_occ     = 1'b0;
    set_tomb    = 1'b0;
    flag_we     = 1'b0;
    flag_addr   = clr_q;
    flag_wdata  = 2'b00;
    unique case (state_q)
      BS_CLEAR: begin
        flag_we = 1'b1;
        clr_d   = clr_q + AW'(1);
        if (clr_q == AW'(Capacity - 1)) state_d = BS_IDLE;
      end
      BS_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          pos_d       = home_big[AW-1:0];
          have_tomb_d = 1'b0;
          steps_d     = '0;
          status_d    = ST_MISS;
          rd_d        = '0;
          state_d     = (req_i.func == FUNC_NOP) ? BS_REPLY : BS_READ;
        end
      end
      BS_READ: state_d = BS_WAIT;
      BS_WAIT: state_d = BS_CHECK;
      BS_CHECK: begin
        state_d = BS_REPLY;
        if (!rocc_q && !rtomb_q) begin
          if (req_q.func == FUNC_SET) begin
            wr_en    = 1'b1;
            wr_full  = 1'b1;
            set_occ  = 1'b1;
            wr_addr  = have_tomb_q ? tpos_q : pos_q;
            status_d = ST_OK;
          end
        end else if (rtomb_q) begin
          if (!have_tomb_q) begin
            have_tomb_d = 1'b1;
            tpos_d      = pos_q;
          end
          state_d = BS_READ;
        end else if (rlen_q == req_q.key_len && rkey_q == req_q.key) begin
          status_d = ST_OK;
          if (req_q.func == FUNC_SET) begin
            wr_en = 1'b1;
          end else if (req_q.func == FUNC_GET) begin
            rd_d = rval_q;
          end else begin
            set_tomb = 1'b1;
          end
        end else begin
          state_d = BS_READ;
        end
        if (state_d == BS_READ) begin
          pos_d   = (pos_q == AW'(Capacity - 1)) ? '0 : pos_q + AW'(1);
          steps_d = steps_q + CW'(1);
          if (steps_q + CW'(1) == CapCount) begin
            state_d = BS_REPLY;
            if (req_q.func == FUNC_SET) begin
              if (have_tomb_d) begin
                wr_en    = 1'b1;
                wr_full  = 1'b1;
                set_occ  = 1'b1;
                wr_addr  = tpos_d;
                status_d = ST_OK;
              end else begin
                status_d = ST_FULL;
              end
            end
          end
        end
      end
      BS_REPLY: begin
        valid_o = 1'b1;
        if (ready_i) state_d = BS_IDLE;
      end
      default: state_d = BS_IDLE;
    endcase
    if (set_occ) begin
      flag_we    = 1'b1;
      flag_addr  = wr_addr;
      flag_wdata = 2'b10;
    end
    if (set_tomb) begin
      flag_we    = 1'b1;
      flag_addr  = pos_q;
      flag_wdata = 2'b01;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BS_IDLE && req_valid_i) req_q <= req_i;
    pos_q       <= pos_d;
    tpos_q      <= tpos_d;
    have_tomb_q <= have_tomb_d;
    steps_q     <= steps_d;
    status_q    <= status_d;
    rd_q        <= rd_d;
  end

  // Registered memory read of the probed slot.
  always_ff @(posedge clk_i) begin
    if (state_q == BS_READ) begin
      rkey_q            <= key_mem[pos_q];
      rlen_q            <= len_mem[pos_q];
      rval_q            <= val_mem[pos_q];
      {rocc_q, rtomb_q} <= flag_mem[pos_q];
    end
    if (flag_we) flag_mem[flag_addr] <= flag_wdata;
    if (wr_en) begin
      val_mem[wr_addr] <= req_q.value;
      if (wr_full) begin
        key_mem[wr_addr] <= req_q.key;
        len_mem[wr_addr] <= req_q.key_len;
      end
    end
  end

  assign status_o     = status_q;
  assign read_value_o = rd_q;

endmodule

// ----- sim/tb_hash_table_linear_probe_engine.sv -----
module tb_hash_table_linear_probe_engine;
  import htlp_pkg::*;

  localparam int Slots = 256;
  localparam int MaxKeyBytes = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        ready_o;
  logic [1:0]  func_i = FUNC_GET;
  logic [3:0]  key_len_i = '0;
  logic [63:0] key_bytes_i = '0;
  logic [63:0] write_value_i = '0;
  logic        valid_o;
  logic        ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [63:0] read_value_o;

  hash_table_linear_probe_engine uut (
    .clk_i, .rst_ni, .valid_i, .ready_o, .func_i, .key_len_i, .key_bytes_i,
    .write_value_i, .valid_o, .ready_i, .status_o, .read_value_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] value;
  } reply_t;

  // Predictor copy of the table.
  logic [63:0] tbl_key [Slots];
  logic [3:0]  tbl_len [Slots];
  logic [63:0] tbl_val [Slots];
  bit          tbl_occ [Slots];
  bit          tbl_tomb[Slots];
  int          tbl_count;

  reply_t      reply_q[$];
  int          errors = 0;
  int          send_idle = 0;
  int          recv_stall = 0;
  int          hold_off = 0;

  function automatic int unsigned fnv_home(logic [63:0] key, int len);
    logic [63:0] h;
    h = FnvBasis;
    for (int b = 0; b < len; b++) begin
      h = h ^ {56'd0, key[8*b +: 8]};
      h = h * FnvPrime;
    end
    return 32'(h % 64'(Slots));
  endfunction

  function automatic reply_t table_apply(logic [1:0] fn, logic [3:0] len_in,
                                         logic [63:0] key_in, logic [63:0] val);
    reply_t r;
    int len, pos, tomb;
    int unsigned home;
    bit have_tomb, done;
    logic [63:0] key;
    r = '{status: ST_MISS, value: '0};
    len = (len_in > MaxKeyBytes) ? MaxKeyBytes : len_in;
    key = key_in;
    if (len < 8) key = key & ((64'd1 << (8 * len)) - 64'd1);
    home = fnv_home(key, len);
    have_tomb = 0;
    done = 0;
    tomb = 0;
    for (int i = 0; i < Slots && !done && fn != FUNC_NOP; i++) begin
      pos = (home + i) % Slots;
      if (!tbl_occ[pos] && !tbl_tomb[pos]) begin
        if (fn == FUNC_SET) begin
          if (have_tomb) pos = tomb;
          tbl_key[pos] = key; tbl_len[pos] = 4'(len); tbl_val[pos] = val;
          tbl_occ[pos] = 1; tbl_tomb[pos] = 0; tbl_count++;
          r.status = ST_OK;
        end
        done = 1;
      end else if (tbl_tomb[pos]) begin
        if (!have_tomb) begin
          have_tomb = 1;
          tomb = pos;
        end
      end else if (tbl_len[pos] == len && tbl_key[pos] == key) begin
        if (fn == FUNC_SET) tbl_val[pos] = val;
        else if (fn == FUNC_GET) r.value = tbl_val[pos];
        else begin
          tbl_occ[pos] = 0; tbl_tomb[pos] = 1;
          if (tbl_count > 0) tbl_count--;
        end
        r.status = ST_OK;
        done = 1;
      end
    end
    if (fn == FUNC_SET && !done) begin
      if (have_tomb) begin
        tbl_key[tomb] = key; tbl_len[tomb] = 4'(len); tbl_val[tomb] = val;
        tbl_occ[tomb] = 1; tbl_tomb[tomb] = 0; tbl_count++;
        r.status = ST_OK;
      end else r.status = ST_FULL;
    end
    return r;
  endfunction

  // Send one transaction; the predicted reply is queued at acceptance.
  task automatic send_req(logic [1:0] fn, logic [3:0] len, logic [63:0] key,
                          logic [63:0] val, bit check_typed, reply_t typed);
    reply_t r;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    func_i <= fn; key_len_i <= len; key_bytes_i <= key; write_value_i <= val;
    valid_i <= 1'b1;
    do @(posedge clk_i); while (!ready_o);
    r = table_apply(fn, len, key, val);
    if (check_typed && r !== typed) begin
      $display("%0t: table row predicts %h, predictor %h", $time, typed, r);
      errors++;
    end
    reply_q.push_back(r);
  endtask

  always @(posedge clk_i) begin
    reply_t exp_r;
    if (rst_ni && valid_o && ready_i) begin
      if (reply_q.size() == 0) begin
        $display("%0t: unexpected reply status %0d value %h", $time, status_o,
                 read_value_o);
        errors++;
      end else begin
        exp_r = reply_q.pop_front();
        if (status_o !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                   status_o);
          errors++;
        end
        if (read_value_o !== exp_r.value) begin
          $display("%0t: read_value expected %h actual %h", $time, exp_r.value,
                   read_value_o);
          errors++;
        end
      end
    end
  end

  // Receiver back-pressure; a hold-off counts down in cycles.
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      ready_i <= 1'b0;
    end else begin
      ready_i <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
    end
  end

  initial begin
    #100000000;
    $display("RESULT: ERROR");
    $finish;
  end

  typedef struct {
    logic [1:0]  fn;
    logic [3:0]  len;
    logic [63:0] key;
    logic [63:0] val;
    bit          typed;
    logic [1:0]  st;
    logic [63:0] rv;
  } row_t;

  row_t rows[$];
  logic [63:0] pool[16];

  task automatic drain();
    valid_i <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic random_phase(int n, int s_idle, int r_stall);
    int pick;
    logic [1:0] fn;
    logic [3:0] len;
    logic [63:0] key;
    send_idle = s_idle;
    recv_stall = r_stall;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      fn = (pick < 45) ? FUNC_SET : (pick < 75) ? FUNC_GET : (pick < 97) ? FUNC_DEL
                                                                          : FUNC_NOP;
      if ($urandom_range(9) < 8) begin
        key = pool[$urandom_range(15)];
        len = 4'($urandom_range(8));
        if ($urandom_range(9) == 0) len = 4'($urandom_range(15));
        // garbage above the key length must be ignored
        if (len < 8 && $urandom_range(1)) key = key | ({$urandom, $urandom} << (8 * len));
      end else begin
        key = {$urandom, $urandom};
        len = 4'($urandom_range(15));
      end
      send_req(fn, len, key, {$urandom, $urandom}, 0, '0);
    end
  endtask

  initial begin
    reply_t typed;
    for (int i = 0; i < Slots; i++) begin
      tbl_occ[i] = 0; tbl_tomb[i] = 0;
    end
    tbl_count = 0;
    for (int i = 0; i < 16; i++) pool[i] = {$urandom, $urandom};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rows.push_back('{FUNC_GET, 4'd0, 64'd0, 64'd0, 1, ST_MISS, 64'd0});
    rows.push_back('{FUNC_DEL, 4'd8, '1, 64'd0, 1, ST_MISS, 64'd0});
    rows.push_back('{FUNC_SET, 4'd0, '1, '1, 1, ST_OK, 64'd0});
    rows.push_back('{FUNC_GET, 4'd0, 64'h55, 64'd0, 1, ST_OK, '1});
    rows.push_back('{FUNC_SET, 4'd8, '1, 64'hA5A5_5A5A_0F0F_F0F0, 1, ST_OK, 64'd0});
    rows.push_back('{FUNC_GET, 4'd15, '1, 64'd0, 1, ST_OK, 64'hA5A5_5A5A_0F0F_F0F0});
    rows.push_back('{FUNC_SET, 4'd1, 64'hFFFF_FF12, 64'd7, 1, ST_OK, 64'd0});
    rows.push_back('{FUNC_GET, 4'd1, 64'h12, 64'd0, 1, ST_OK, 64'd7});
    rows.push_back('{FUNC_GET, 4'd2, 64'h12, 64'd0, 0, ST_MISS, 64'd0});
    rows.push_back('{FUNC_SET, 4'd1, 64'h12, 64'd9, 1, ST_OK, 64'd0});
    rows.push_back('{FUNC_GET, 4'd1, 64'hAB12, 64'd0, 1, ST_OK, 64'd9});
    rows.push_back('{FUNC_NOP, 4'd1, 64'h12, 64'd1, 1, ST_MISS, 64'd0});
    rows.push_back('{FUNC_DEL, 4'd1, 64'h12, 64'd0, 1, ST_OK, 64'd0});
    rows.push_back('{FUNC_GET, 4'd1, 64'h12, 64'd0, 1, ST_MISS, 64'd0});
    rows.push_back('{FUNC_DEL, 4'd1, 64'h12, 64'd0, 1, ST_MISS, 64'd0});
    rows.push_back('{FUNC_SET, 4'd1, 64'h12, 64'd3, 1, ST_OK, 64'd0});
    rows.push_back('{FUNC_GET, 4'd1, 64'h12, 64'd0, 1, ST_OK, 64'd3});
    rows.push_back('{FUNC_SET, 4'd4, 64'h0123_4567_89AB_CDEF, 64'd0, 1, ST_OK, 64'd0});
    rows.push_back('{FUNC_GET, 4'd4, 64'h89AB_CDEF, 64'd0, 1, ST_OK, 64'd0});
    rows.push_back('{FUNC_NOP, 4'd15, '1, '1, 1, ST_MISS, 64'd0});
    foreach (rows[i]) begin
      typed = '{status: rows[i].st, value: rows[i].rv};
      send_req(rows[i].fn, rows[i].len, rows[i].key, rows[i].val, rows[i].typed, typed);
    end
    drain();

    random_phase(120, 0, 0);
    random_phase(100, 72, 0);
    random_phase(100, 0, 72);
    random_phase(100, 29, 29);

    // Long receiver hold-off so the queue fills and ready_o drops.
    send_idle = 0;
    recv_stall = 0;
    hold_off = 300;
    random_phase(20, 0, 0);
    drain();

    // Fill the table to reach the full case, then churn with deletes.
    for (int i = 0; i < Slots + 4; i++)
      send_req(FUNC_SET, 4'd4, 64'(i), {$urandom, $urandom}, 0, '0);
    send_req(FUNC_SET, 4'd8, '1, 64'd1, 0, '0);
    random_phase(60, 29, 29);
    for (int i = 0; i < Slots; i++) send_req(FUNC_DEL, 4'd4, 64'(i), 64'd0, 0, '0);
    random_phase(80, 0, 0);

    drain();
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
